@@ hdl/cdu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constraint dual update - shared package
// Payload types, register codes, reset values and the sequencer microprogram.
// ----------------------------------------------------------------------------
package cdu_pkg;

  // Field widths
  localparam int WORD_W    = 32;  // every Q16.16 word on the ports
  localparam int KIND_W    = 2;
  localparam int START_W   = 31;
  localparam int FRAC_W    = 17;  // alpha and gamma
  localparam int BETA_W    = 31;
  localparam int REG_IDX_W = 3;

  // Datapath widths
  localparam int OPND_W = 33;           // multiplier operand, holds every source
  localparam int PROD_W = 2 * OPND_W;   // full product
  localparam int WIDE_W = 52;           // rounded products and sums before saturation

  localparam int DATA_WIDTH_DEF = 32;

  // Register reset values
  localparam logic [START_W-1:0]       START_RST    = 31'd65536;
  localparam logic signed [WORD_W-1:0] MULT_MIN_RST = 32'h8000_0000;
  localparam logic signed [WORD_W-1:0] MULT_MAX_RST = 32'h7fff_ffff;
  localparam logic [FRAC_W-1:0]        ALPHA_RST    = 17'd62259;
  localparam logic [FRAC_W-1:0]        GAMMA_RST    = 17'd64881;
  localparam logic [BETA_W-1:0]        BETA_RST     = 31'd655360;
  localparam logic signed [WORD_W-1:0] STIFF_RST    = 32'sd65536;

  // Request kinds; the unused code behaves as a query
  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_STEP   = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_START    = 3'd0,
    REG_MULT_MIN = 3'd1,
    REG_MULT_MAX = 3'd2,
    REG_ALPHA    = 3'd3,
    REG_GAMMA    = 3'd4,
    REG_BETA     = 3'd5
  } reg_idx_t;

  // Channel payloads
  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [WORD_W-1:0]   raw_constraint;
    logic signed [WORD_W-1:0]   grad_x;
    logic signed [WORD_W-1:0]   grad_y;
    logic signed [WORD_W-1:0]   grad_z;
  } cdu_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   energy_value;
    logic signed [WORD_W-1:0]   force_x;
    logic signed [WORD_W-1:0]   force_y;
    logic signed [WORD_W-1:0]   force_z;
    logic signed [WORD_W-1:0]   multiplier_out;
    logic signed [WORD_W-1:0]   stiffness_out;
    logic                       saturated;
  } cdu_out_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0]       index;
    logic [WORD_W-1:0]          data;
  } cdu_cfg_t;

  // Saturation result
  typedef struct packed {
    logic                       hit;
    logic signed [WORD_W-1:0]   val;
  } sat_t;

  // Microcode fields
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    A_ALPHA, A_STIFF, A_KC, A_MULT, A_LC, A_BETA, A_GAMMA, A_GA
  } a_sel_t;

  typedef enum logic [2:0] {
    B_PREV, B_C, B_GX, B_GY, B_GZ, B_STIFF, B_ALPHA, B_MULT
  } b_sel_t;

  typedef enum logic [3:0] {
    P_NONE,    // nothing to write back
    P_C,       // stabilised constraint
    P_KC,      // stiffness times constraint
    P_E2A,     // multiplier term of the energy, held unsaturated
    P_ENERGY,  // quadratic term plus held term
    P_LP,      // raw and clamped multiplier, limit test
    P_FX,
    P_FY,
    P_FZ,
    P_UPDATE,  // iteration update of the state
    P_K2,      // decayed stiffness with floor
    P_GA,      // gamma times alpha
    P_DECAY    // decayed multiplier
  } post_t;

  typedef enum logic [1:0] {
    J_NEXT, J_ALWAYS, J_IF_QUERY, J_IF_STEP
  } jump_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul_en;   // load the product register this step
    post_t  post;     // write back the product of the step before
    jump_t  jump;
    step_t  target;
    logic   last;     // hand the result over and release the sequencer
  } ctrl_t;

  localparam step_t STEP_STEP = 5'd13;
  localparam step_t STEP_DONE = 5'd18;

  // Microprogram
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    w = '{A_ALPHA, B_PREV, 1'b0, P_NONE, J_NEXT, STEP_DONE, 1'b0};
    case (pc)
      step_t'(0):  w = '{A_ALPHA, B_PREV,  1'b1, P_NONE,   J_NEXT,     STEP_DONE, 1'b0};
      step_t'(1):  w = '{A_ALPHA, B_PREV,  1'b0, P_C,      J_NEXT,     STEP_DONE, 1'b0};
      step_t'(2):  w = '{A_STIFF, B_C,     1'b1, P_NONE,   J_NEXT,     STEP_DONE, 1'b0};
      step_t'(3):  w = '{A_MULT,  B_C,     1'b1, P_KC,     J_NEXT,     STEP_DONE, 1'b0};
      step_t'(4):  w = '{A_KC,    B_C,     1'b1, P_E2A,    J_NEXT,     STEP_DONE, 1'b0};
      step_t'(5):  w = '{A_ALPHA, B_PREV,  1'b0, P_ENERGY, J_NEXT,     STEP_DONE, 1'b0};
      step_t'(6):  w = '{A_ALPHA, B_PREV,  1'b0, P_LP,     J_NEXT,     STEP_DONE, 1'b0};
      step_t'(7):  w = '{A_LC,    B_GX,    1'b1, P_NONE,   J_NEXT,     STEP_DONE, 1'b0};
      step_t'(8):  w = '{A_LC,    B_GY,    1'b1, P_FX,     J_NEXT,     STEP_DONE, 1'b0};
      step_t'(9):  w = '{A_LC,    B_GZ,    1'b1, P_FY,     J_NEXT,     STEP_DONE, 1'b0};
      step_t'(10): w = '{A_ALPHA, B_PREV,  1'b0, P_FZ,     J_IF_QUERY, STEP_DONE, 1'b0};
      step_t'(11): w = '{A_BETA,  B_C,     1'b1, P_NONE,   J_IF_STEP,  STEP_STEP, 1'b0};
      step_t'(12): w = '{A_ALPHA, B_PREV,  1'b0, P_UPDATE, J_ALWAYS,   STEP_DONE, 1'b0};
      step_t'(13): w = '{A_GAMMA, B_STIFF, 1'b1, P_NONE,   J_NEXT,     STEP_DONE, 1'b0};
      step_t'(14): w = '{A_GAMMA, B_ALPHA, 1'b1, P_K2,     J_NEXT,     STEP_DONE, 1'b0};
      step_t'(15): w = '{A_ALPHA, B_PREV,  1'b0, P_GA,     J_NEXT,     STEP_DONE, 1'b0};
      step_t'(16): w = '{A_GA,    B_MULT,  1'b1, P_NONE,   J_NEXT,     STEP_DONE, 1'b0};
      step_t'(17): w = '{A_ALPHA, B_PREV,  1'b0, P_DECAY,  J_NEXT,     STEP_DONE, 1'b0};
      default:     w = '{A_ALPHA, B_PREV,  1'b0, P_NONE,   J_NEXT,     STEP_DONE, 1'b1};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/cdu_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constraint dual update - handshake channel
// Valid/ready channel carrying one payload of the given type.
// ----------------------------------------------------------------------------
interface cdu_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/constraint_dual_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constraint dual update unit
// Augmented Lagrangian state of one hard constraint, driven by a microcoded
// sequencer around one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   item   - request channel: kind, raw constraint and its gradient.
//   result - one result per request: energy and force from the state before
//            the action, multiplier and stiffness after it, saturation flag.
//   cfg    - register writes (index, data); always ready. Write only while
//            the unit is idle.
// Timing: every product goes through the one multiplier and the products form
//   a dependent chain, worked through by the sequencer with write-back steps
//   between them. A query stops after the forces, an iteration update adds the
//   state update, a time step the stiffness and multiplier decay instead. A new
//   request is taken only once the sequencer has released the last one.
// The result sits in its own register, so the next request is taken and
//   worked on while an earlier result waits. If the receiver still stalls when
//   the next result is due, the sequencer holds on its last step.
// Reset: synchronous; loads the register defaults, sets stiffness to the
//   default start value, clears multiplier and previous constraint.
// ----------------------------------------------------------------------------
module constraint_dual_update_unit
  import cdu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cdu_chan_if.sink   item,
  cdu_chan_if.source result,
  cdu_chan_if.sink   cfg
);

  // Saturation width: the data width held to 24..32 bits
  localparam int SW = (DATA_WIDTH > WORD_W) ? WORD_W :
                      ((DATA_WIDTH < 24) ? 24 : DATA_WIDTH);
  localparam logic signed [WIDE_W-1:0] SAT_HI = (52'sd1 <<< (SW - 1)) - 52'sd1;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - 52'sd1;
  localparam logic signed [PROD_W-1:0] HALF16 = 66'sd32768;
  localparam logic signed [PROD_W-1:0] HALF17 = 66'sd65536;

  function automatic sat_t sat_w(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.hit = 1'b1;
      r.val = SAT_HI[WORD_W-1:0];
    end else if (v < SAT_LO) begin
      r.hit = 1'b1;
      r.val = SAT_LO[WORD_W-1:0];
    end else begin
      r.hit = 1'b0;
      r.val = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [START_W-1:0]       stiffness_start;
  logic signed [WORD_W-1:0] mult_min;
  logic signed [WORD_W-1:0] mult_max;
  logic [FRAC_W-1:0]        alpha;
  logic [FRAC_W-1:0]        gamma;
  logic [BETA_W-1:0]        beta;

  // Constraint state
  logic signed [WORD_W-1:0] stiffness, stiffness_next;
  logic signed [WORD_W-1:0] multiplier, multiplier_next;
  logic signed [WORD_W-1:0] prev, prev_next;

  // Sequencer
  logic  busy;
  step_t pc, pc_next;
  ctrl_t ctl;
  logic  take;
  logic  advance;

  // Latched request
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] raw;
  logic signed [WORD_W-1:0] gx, gy, gz;

  // Datapath registers
  logic signed [OPND_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [WORD_W-1:0] c, c_next;
  logic signed [WORD_W-1:0] kc, kc_next;
  logic signed [WIDE_W-1:0] acc, acc_next;
  logic signed [WORD_W-1:0] energy, energy_next;
  logic signed [WORD_W-1:0] lc, lc_next;
  logic                     in_lim, in_lim_next;
  logic signed [WORD_W-1:0] fx, fx_next;
  logic signed [WORD_W-1:0] fy, fy_next;
  logic signed [WORD_W-1:0] fz, fz_next;
  logic signed [WORD_W-1:0] ga, ga_next;
  logic                     sat_flag, sat_flag_next;

  // Result register
  cdu_out_t res;
  logic     res_valid;

  // Rounded products
  logic signed [PROD_W-1:0] rnd16_full, rnd17_full;
  logic signed [WIDE_W-1:0] rs16, rs17;

  assign ctl     = ucode(pc);
  assign advance = busy && !(ctl.last && res_valid && !result.ready);

  assign item.ready     = !busy;
  assign cfg.ready      = 1'b1;
  assign result.valid   = res_valid;
  assign result.payload = res;

  // Operand selection for the shared multiplier
  always_comb begin
    case (ctl.a_sel)
      A_ALPHA: opa = $signed({{(OPND_W - FRAC_W){1'b0}}, alpha});
      A_STIFF: opa = OPND_W'(stiffness);
      A_KC:    opa = OPND_W'(kc);
      A_MULT:  opa = OPND_W'(multiplier);
      A_LC:    opa = OPND_W'(lc);
      A_BETA:  opa = $signed({{(OPND_W - BETA_W){1'b0}}, beta});
      A_GAMMA: opa = $signed({{(OPND_W - FRAC_W){1'b0}}, gamma});
      A_GA:    opa = OPND_W'(ga);
      default: opa = '0;
    endcase
    case (ctl.b_sel)
      B_PREV:  opb = OPND_W'(prev);
      B_C:     opb = OPND_W'(c);
      B_GX:    opb = OPND_W'(gx);
      B_GY:    opb = OPND_W'(gy);
      B_GZ:    opb = OPND_W'(gz);
      B_STIFF: opb = OPND_W'(stiffness);
      B_ALPHA: opb = $signed({{(OPND_W - FRAC_W){1'b0}}, alpha});
      B_MULT:  opb = OPND_W'(multiplier);
      default: opb = '0;
    endcase
  end

  // Round to nearest, ties up: add half, then arithmetic shift
  always_comb begin
    rnd16_full = (prod + HALF16) >>> 16;
    rnd17_full = (prod + HALF17) >>> 17;
    rs16       = rnd16_full[WIDE_W-1:0];
    rs17       = rnd17_full[WIDE_W-1:0];
  end

  // Write-back of the product taken in the step before
  always_comb begin
    sat_t s1, s2;
    logic signed [WORD_W-1:0] lp, clamped, t1;
    logic signed [WIDE_W-1:0] startw, k2w;
    logic hit;

    s1      = '0;
    s2      = '0;
    lp      = '0;
    clamped = '0;
    t1      = '0;
    startw  = WIDE_W'($signed({1'b0, stiffness_start}));
    k2w     = '0;
    hit     = 1'b0;

    c_next          = c;
    kc_next         = kc;
    acc_next        = acc;
    energy_next     = energy;
    lc_next         = lc;
    in_lim_next     = in_lim;
    fx_next         = fx;
    fy_next         = fy;
    fz_next         = fz;
    ga_next         = ga;
    stiffness_next  = stiffness;
    multiplier_next = multiplier;
    prev_next       = prev;

    case (ctl.post)
      P_C: begin
        s1     = sat_w(WIDE_W'(raw) - rs16);
        c_next = s1.val;
        hit    = s1.hit;
      end
      P_KC: begin
        s1      = sat_w(rs16);
        kc_next = s1.val;
        hit     = s1.hit;
      end
      P_E2A: begin
        acc_next = rs16;
      end
      P_ENERGY: begin
        s1          = sat_w(rs17 + acc);
        energy_next = s1.val;
        hit         = s1.hit;
      end
      P_LP: begin
        s1          = sat_w(WIDE_W'(kc) + WIDE_W'(multiplier));
        lp          = s1.val;
        clamped     = (lp < mult_max) ? lp : mult_max;
        clamped     = (clamped > mult_min) ? clamped : mult_min;
        s2          = sat_w(WIDE_W'(clamped));
        lc_next     = s2.val;
        in_lim_next = (lp > mult_min) && (lp < mult_max);
        hit         = s1.hit | s2.hit;
      end
      P_FX: begin
        s1      = sat_w(rs16);
        fx_next = s1.val;
        hit     = s1.hit;
      end
      P_FY: begin
        s1      = sat_w(rs16);
        fy_next = s1.val;
        hit     = s1.hit;
      end
      P_FZ: begin
        s1      = sat_w(rs16);
        fz_next = s1.val;
        hit     = s1.hit;
      end
      P_UPDATE: begin
        multiplier_next = lc;
        // ramp stiffness and move the reference only off the limits
        if (in_lim) begin
          s1             = sat_w(rs16);
          t1             = s1.val;
          s2             = sat_w(WIDE_W'(stiffness) + WIDE_W'(t1));
          stiffness_next = s2.val;
          prev_next      = raw;
          hit            = s1.hit | s2.hit;
        end
      end
      P_K2: begin
        s1             = sat_w(rs16);
        t1             = s1.val;
        k2w            = WIDE_W'(t1);
        s2             = sat_w((k2w > startw) ? k2w : startw);
        stiffness_next = s2.val;
        hit            = s1.hit | s2.hit;
      end
      P_GA: begin
        s1      = sat_w(rs16);
        ga_next = s1.val;
        hit     = s1.hit;
      end
      P_DECAY: begin
        s1              = sat_w(rs16);
        multiplier_next = s1.val;
        hit             = s1.hit;
      end
      default: begin
      end
    endcase

    sat_flag_next = sat_flag | hit;
  end

  // Next step
  always_comb begin
    case (ctl.jump)
      J_NEXT:     take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_IF_QUERY: take = !(kind inside {KIND_UPDATE, KIND_STEP});
      J_IF_STEP:  take = (kind == KIND_STEP);
      default:    take = 1'b0;
    endcase
    pc_next = take ? ctl.target : pc + step_t'(1);
  end

  // Control, configuration and constraint state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      pc              <= '0;
      res_valid       <= 1'b0;
      stiffness_start <= START_RST;
      mult_min        <= MULT_MIN_RST;
      mult_max        <= MULT_MAX_RST;
      alpha           <= ALPHA_RST;
      gamma           <= GAMMA_RST;
      beta            <= BETA_RST;
      stiffness       <= STIFF_RST;
      multiplier      <= '0;
      prev            <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.payload.index)
          REG_START:    stiffness_start <= cfg.payload.data[START_W-1:0];
          REG_MULT_MIN: mult_min        <= cfg.payload.data;
          REG_MULT_MAX: mult_max        <= cfg.payload.data;
          REG_ALPHA:    alpha           <= cfg.payload.data[FRAC_W-1:0];
          REG_GAMMA:    gamma           <= cfg.payload.data[FRAC_W-1:0];
          REG_BETA:     beta            <= cfg.payload.data[BETA_W-1:0];
          default: begin
            // drop writes to unknown indexes
          end
        endcase
      end

      // load a new result, else drop the one the receiver has taken
      if (advance && ctl.last) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (!busy) begin
        if (item.valid) begin
          busy <= 1'b1;
          pc   <= '0;
        end
      end else if (advance) begin
        pc         <= pc_next;
        stiffness  <= stiffness_next;
        multiplier <= multiplier_next;
        prev       <= prev_next;
        if (ctl.last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Request capture, datapath and result payload
  always_ff @(posedge clk) begin
    if (!busy && item.valid) begin
      kind     <= item.payload.kind;
      raw      <= item.payload.raw_constraint;
      gx       <= item.payload.grad_x;
      gy       <= item.payload.grad_y;
      gz       <= item.payload.grad_z;
      sat_flag <= 1'b0;
    end else if (advance) begin
      if (ctl.mul_en) begin
        prod <= opa * opb;
      end
      c        <= c_next;
      kc       <= kc_next;
      acc      <= acc_next;
      energy   <= energy_next;
      lc       <= lc_next;
      in_lim   <= in_lim_next;
      fx       <= fx_next;
      fy       <= fy_next;
      fz       <= fz_next;
      ga       <= ga_next;
      sat_flag <= sat_flag_next;
      if (ctl.last) begin
        res <= '{energy_value:   energy,
                 force_x:        fx,
                 force_y:        fy,
                 force_z:        fz,
                 multiplier_out: multiplier,
                 stiffness_out:  stiffness,
                 saturated:      sat_flag};
      end
    end
  end

endmodule
